// File: hdl/chromatic_number_backtrack_core_defines.svh
`ifndef CHROMATIC_NUMBER_BACKTRACK_CORE_DEFINES_SVH
`define CHROMATIC_NUMBER_BACKTRACK_CORE_DEFINES_SVH

// Plain check, sampled on every rising clock edge outside reset
`define CNB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication
`define CNB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CNB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cnb_pkg.sv
`default_nettype none

package cnb_pkg;

  // Graph size limit
  localparam int MAX_VERTICES = 16;

  // Vertex index and count/color widths
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

  // Fixed port field widths
  localparam int END_W   = 4;
  localparam int COUNT_W = 5;

  // Controller to datapath commands
  typedef struct packed {
    logic edge_wr;
    logic scan;
    logic place;
    logic backtrack;
    logic next_limit;
    logic finish;
  } cnb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;
    logic at_last;
    logic at_root;
  } cnb_sts_t;

endpackage

`default_nettype wire

// File: hdl/chromatic_number_backtrack_core.sv
// Channel   | Signals                                   | Direction | Handshake
// ----------+-------------------------------------------+-----------+-------------------
// edge      | end_a_i, end_b_i, last_edge_i             | in        | start && !busy
// result    | min_colors_o                              | out       | result_strobe_o
// config    | cfg_data_i (vertex_count)                 | in        | cfg_valid_i && cfg_ready_o
//
// An ordinary edge is taken while idle; edges can be written back to back.
// The last edge starts the backtracking search: each step runs ST_SCAN (neighbor color
// scan), then ST_PICK (pick/place/backtrack); the step count depends on the graph and is
// exponential in the worst case; the result strobes in the cycle after the final step.
// Reset clears the adjacency matrix and search state, vertex_count resets to 1.
// The result is shown for one cycle only; cfg_ready_o is low while the search runs.
`default_nettype none

module chromatic_number_backtrack_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [cnb_pkg::END_W-1:0]   end_a_i,
  input  logic [cnb_pkg::END_W-1:0]   end_b_i,
  input  logic                        last_edge_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cnb_pkg::COUNT_W-1:0] cfg_data_i,
  output logic                        result_strobe_o,
  output logic [cnb_pkg::COUNT_W-1:0] min_colors_o
);
  import cnb_pkg::*;

  cnb_cmd_t cmd;
  cnb_sts_t sts;
  logic     cfg_wr;

  // Config accepted only when the search is idle
  assign cfg_ready_o = !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  cnb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .last_edge_i     (last_edge_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .busy_o          (busy),
    .result_strobe_o (result_strobe_o)
  );

  cnb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .end_a_i      (end_a_i),
    .end_b_i      (end_b_i),
    .cfg_wr_i     (cfg_wr),
    .cfg_data_i   (cfg_data_i),
    .min_colors_o (min_colors_o)
  );

endmodule

`default_nettype wire

// File: hdl/cnb_ctrl.sv
`default_nettype none
`include "chromatic_number_backtrack_core_defines.svh"

module cnb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_edge_i,
  input  cnb_pkg::cnb_sts_t sts_i,
  output cnb_pkg::cnb_cmd_t cmd_o,
  output logic             busy_o,
  output logic             result_strobe_o
);
  import cnb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PICK = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;
  logic   last_req;

  assign busy_o          = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;

  // Last edge request accepted
  assign last_req = start_i && !busy_o && last_edge_i;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    strobe_d = 1'b0;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.edge_wr = 1'b1;
          if (last_edge_i) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = ST_PICK;
      end
      ST_PICK: begin
        state_d = ST_SCAN;
        priority if (sts_i.found && sts_i.at_last) begin
          cmd_o.finish = 1'b1;
          strobe_d     = 1'b1;
          state_d      = ST_IDLE;
        end else if (sts_i.found) begin
          cmd_o.place = 1'b1;
        end else if (sts_i.at_root) begin
          cmd_o.next_limit = 1'b1;
        end else begin
          cmd_o.backtrack = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  `CNB_ASSERT_IMP(a_strobe_after_pick, strobe_q, $past(state_q == ST_PICK), "strobe w/o pick")
  `CNB_ASSERT_NXT(a_last_starts_search, last_req, state_q == ST_SCAN, "search not started")

endmodule

`default_nettype wire

// File: hdl/cnb_datapath.sv
`default_nettype none
`include "chromatic_number_backtrack_core_defines.svh"

module cnb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cnb_pkg::cnb_cmd_t             cmd_i,
  output cnb_pkg::cnb_sts_t             sts_o,
  input  logic [cnb_pkg::END_W-1:0]     end_a_i,
  input  logic [cnb_pkg::END_W-1:0]     end_b_i,
  input  logic                          cfg_wr_i,
  input  logic [cnb_pkg::COUNT_W-1:0]   cfg_data_i,
  output logic [cnb_pkg::COUNT_W-1:0]   min_colors_o
);
  import cnb_pkg::*;

  logic [MAX_VERTICES-1:0] adj_q    [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_d    [MAX_VERTICES];
  logic [CNT_W-1:0]        colors_q [MAX_VERTICES];
  logic [CNT_W-1:0]        colors_d [MAX_VERTICES];
  logic [MAX_VERTICES:0]   used_q, used_d;
  logic [VIDX_W-1:0]       depth_q, depth_d;
  logic [CNT_W-1:0]        limit_q, limit_d;
  logic [COUNT_W-1:0]      vcount_q;
  logic [COUNT_W-1:0]      result_q;

  logic [CNT_W-1:0]        nv;
  logic [VIDX_W-1:0]       nv_last;
  logic [VIDX_W-1:0]       depth_inc;
  logic [VIDX_W-1:0]       idx_a, idx_b;
  logic                    edge_ok;
  logic [MAX_VERTICES:0]   cand;
  logic [CNT_W-1:0]        pick_c;
  logic [CNT_W-1:0]        cur_c;

  // Effective vertex count: zero reads as one, saturate at the limit
  always_comb begin
    if (vcount_q == '0) begin
      nv = CNT_W'(1);
    end else if (int'(vcount_q) > MAX_VERTICES) begin
      nv = CNT_W'(MAX_VERTICES);
    end else begin
      nv = CNT_W'(vcount_q);
    end
  end
  assign nv_last   = VIDX_W'(nv - CNT_W'(1));
  assign depth_inc = depth_q + VIDX_W'(1);

  // Edge decode; self-loops and out-of-range ends are dropped
  assign idx_a   = VIDX_W'(end_a_i);
  assign idx_b   = VIDX_W'(end_b_i);
  assign edge_ok = (end_a_i != end_b_i) && (int'(end_a_i) < MAX_VERTICES)
                   && (int'(end_b_i) < MAX_VERTICES);

  // Lowest free color above the current one, within the trial limit
  assign cur_c = colors_q[depth_q];
  always_comb begin
    cand   = '0;
    pick_c = '0;
    for (int c = 1; c <= MAX_VERTICES; c++) begin
      cand[c] = !used_q[c] && (c > int'(cur_c)) && (c <= int'(limit_q));
    end
    for (int c = MAX_VERTICES; c >= 1; c--) begin
      if (cand[c]) begin
        pick_c = CNT_W'(c);
      end
    end
  end

  assign sts_o.found   = |cand;
  assign sts_o.at_last = (depth_q == nv_last);
  assign sts_o.at_root = (depth_q == '0);

  // Colors used by colored neighbors of the current vertex
  always_comb begin
    used_d = used_q;
    if (cmd_i.scan) begin
      used_d = '0;
      for (int u = 0; u < MAX_VERTICES; u++) begin
        if (adj_q[depth_q][u] && (u < int'(nv))) begin
          used_d[colors_q[u]] = 1'b1;
        end
      end
    end
  end

  // Graph and search state updates
  always_comb begin
    adj_d    = adj_q;
    colors_d = colors_q;
    depth_d  = depth_q;
    limit_d  = limit_q;
    if (cmd_i.edge_wr && edge_ok) begin
      adj_d[idx_a][idx_b] = 1'b1;
      adj_d[idx_b][idx_a] = 1'b1;
    end
    if (cmd_i.place) begin
      colors_d[depth_q]   = pick_c;
      colors_d[depth_inc] = '0;
      depth_d             = depth_inc;
    end
    if (cmd_i.backtrack) begin
      colors_d[depth_q] = '0;
      depth_d           = depth_q - VIDX_W'(1);
    end
    if (cmd_i.next_limit) begin
      colors_d[depth_q] = '0;
      limit_d           = limit_q + CNT_W'(1);
    end
    if (cmd_i.finish) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        adj_d[v]    = '0;
        colors_d[v] = '0;
      end
      depth_d = '0;
      limit_d = CNT_W'(1);
    end
  end

  // Control and graph registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        adj_q[v]    <= '0;
        colors_q[v] <= '0;
      end
      depth_q  <= '0;
      limit_q  <= CNT_W'(1);
      vcount_q <= COUNT_W'(1);
    end else begin
      adj_q    <= adj_d;
      colors_q <= colors_d;
      depth_q  <= depth_d;
      limit_q  <= limit_d;
      if (cfg_wr_i) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    used_q <= used_d;
    if (cmd_i.finish) begin
      result_q <= COUNT_W'(limit_q);
    end
  end

  assign min_colors_o = result_q;

  `CNB_ASSERT(a_depth_in_range, depth_q <= nv_last, "search depth past last vertex")
  `CNB_ASSERT(a_limit_in_range, limit_q <= nv, "trial limit past vertex count")

endmodule

`default_nettype wire

// File: dv/tb_chromatic_number_backtrack_core.sv
module tb_chromatic_number_backtrack_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cnb_pkg::*;

  typedef logic [MAX_VERTICES-1:0] adj_row_t;
  typedef adj_row_t adj_mat_t [MAX_VERTICES];

  // Random graphs whose search would run longer than this many steps are thinned out
  localparam int unsigned STEP_BUDGET  = 1500;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned CFG_SETTLE   = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ROUND_ITEMS  = 150;

  // Tracks the graph under construction and the chromatic numbers still owed by the block
  class coloring_scoreboard;
    adj_mat_t           adj;
    logic [COUNT_W-1:0] vertex_count;
    logic [COUNT_W-1:0] expected_colors [$];
    int unsigned        mismatches;
    int unsigned        graphs_checked;
    int unsigned        edges_taken;

    function new();
      foreach (adj[i]) adj[i] = '0;
      vertex_count   = COUNT_W'(1);
      mismatches     = 0;
      graphs_checked = 0;
      edges_taken    = 0;
    endfunction

    function void set_vertex_count(logic [COUNT_W-1:0] v);
      vertex_count = v;
    endfunction

    // Symmetric store; self-loops and ends past the matrix are dropped
    function void add_edge(inout adj_mat_t m, input logic [END_W-1:0] a,
                           input logic [END_W-1:0] b);
      if (a != b && a < MAX_VERTICES && b < MAX_VERTICES) begin
        m[a][b] = 1'b1;
        m[b][a] = 1'b1;
      end
    endfunction

    // Depth-first coloring, trial limits counted up from one; returns 0 if over budget
    function int unsigned chromatic_number(input adj_mat_t m,
                                           input logic [COUNT_W-1:0] vcount,
                                           input int unsigned budget,
                                           output int unsigned steps);
      int unsigned nv, limit, depth, c, u;
      int unsigned color [MAX_VERTICES];
      bit placed, clash, solved;
      nv = (vcount == 0) ? 1 : vcount;
      if (nv > MAX_VERTICES) nv = MAX_VERTICES;
      steps = 0;
      for (limit = 1; limit <= nv; limit++) begin
        foreach (color[i]) color[i] = 0;
        depth  = 0;
        solved = 1'b0;
        forever begin
          steps++;
          if (steps > budget) return 0;
          if (depth >= nv) begin
            solved = 1'b1;
            break;
          end
          // lowest color above the current one that no colored neighbor holds
          c      = color[depth] + 1;
          placed = 1'b0;
          while (c <= limit && !placed) begin
            clash = 1'b0;
            for (u = 0; u < nv; u++)
              if (m[depth][u] && color[u] == c) clash = 1'b1;
            if (clash) c++;
            else placed = 1'b1;
          end
          if (placed) begin
            color[depth] = c;
            depth++;
            if (depth < nv) color[depth] = 0;
          end else begin
            color[depth] = 0;
            if (depth == 0) break;
            depth--;
          end
        end
        if (solved) return limit;
      end
      return nv;
    endfunction

    function void note_edge(logic [END_W-1:0] a, logic [END_W-1:0] b, logic last);
      int unsigned steps;
      logic [COUNT_W-1:0] colors;
      edges_taken++;
      add_edge(adj, a, b);
      if (last) begin
        colors = COUNT_W'(chromatic_number(adj, vertex_count, 32'hFFFF_FFFF, steps));
        expected_colors = {expected_colors, colors};
        foreach (adj[i]) adj[i] = '0;
      end
    endfunction

    function void check_result(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_colors.size() == 0) begin
        mismatches++;
        $error("min_colors: result with no request waiting, actual %0d", got);
        return;
      end
      want = expected_colors.pop_front();
      graphs_checked++;
      if (got !== want) begin
        mismatches++;
        $error("min_colors mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [END_W-1:0]   end_a_i     = '0;
  logic [END_W-1:0]   end_b_i     = '0;
  logic               last_edge_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i  = '0;
  logic               result_strobe_o;
  logic [COUNT_W-1:0] min_colors_o;

  coloring_scoreboard sb = new();
  int unsigned        send_idle_pct = 8;
  int unsigned        items_sent    = 0;
  int unsigned        cfg_writes    = 0;
  int unsigned        cycle_count   = 0;

  chromatic_number_backtrack_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .end_a_i        (end_a_i),
    .end_b_i        (end_b_i),
    .last_edge_i    (last_edge_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .min_colors_o   (min_colors_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Results cannot be held off: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(min_colors_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One edge request; start stays high into the next request unless a gap is drawn
  task automatic send_edge(input logic [END_W-1:0] a, input logic [END_W-1:0] b,
                           input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    start       <= 1'b1;
    end_a_i     <= a;
    end_b_i     <= b;
    last_edge_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_edge(a, b, last);
    items_sent++;
  endtask

  // Register write, only once the block has drained
  task automatic write_vertex_count(input logic [COUNT_W-1:0] v);
    start <= 1'b0;
    while (sb.expected_colors.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_vertex_count(v);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed edges among live vertices, some self-loops and stray vertices
  task automatic send_random_graph();
    adj_mat_t         trial;
    logic [END_W-1:0] ea [$];
    logic [END_W-1:0] eb [$];
    logic [END_W-1:0] a, b;
    int unsigned      nv, n_edges, steps, k;
    nv = (sb.vertex_count == 0) ? 1 :
         (sb.vertex_count > MAX_VERTICES) ? MAX_VERTICES : sb.vertex_count;
    n_edges = $urandom_range(0, 2 * nv + 2);
    forever begin
      ea.delete();
      eb.delete();
      trial = sb.adj;
      for (k = 0; k < n_edges; k++) begin
        if ($urandom_range(99) < 85 && nv > 1) begin
          a = END_W'($urandom_range(nv - 1));
          do b = END_W'($urandom_range(nv - 1)); while (b == a);
        end else begin
          a = END_W'($urandom_range(MAX_VERTICES - 1));
          b = ($urandom_range(99) < 50) ? a : END_W'($urandom_range(MAX_VERTICES - 1));
        end
        ea = {ea, a};
        eb = {eb, b};
        sb.add_edge(trial, a, b);
      end
      void'(sb.chromatic_number(trial, sb.vertex_count, STEP_BUDGET, steps));
      if (steps <= STEP_BUDGET) break;
      n_edges = n_edges / 2;
    end
    // empty graph goes out as a lone self-loop
    if (n_edges == 0) begin
      a = END_W'($urandom_range(MAX_VERTICES - 1));
      ea = {ea, a};
      eb = {eb, a};
    end
    foreach (ea[i]) send_edge(ea[i], eb[i], i == ea.size() - 1);
  endtask

  initial begin
    int unsigned        round, target, r;
    logic [COUNT_W-1:0] vc;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset vertex count of one, empty graph and extreme vertex labels
    send_edge(4'd0, 4'd0, 1'b1);
    send_edge(4'd15, 4'd0, 1'b0);
    send_edge(4'd0, 4'd15, 1'b1);
    // full size: triangle plus a far edge, closed by a self-loop
    write_vertex_count(5'd16);
    send_edge(4'd0, 4'd1, 1'b0);
    send_edge(4'd1, 4'd2, 1'b0);
    send_edge(4'd2, 4'd0, 1'b0);
    send_edge(4'd15, 4'd14, 1'b0);
    send_edge(4'd3, 4'd3, 1'b1);
    send_edge(4'd0, 4'd0, 1'b1);
    send_edge(4'd5, 4'd9, 1'b1);
    // zero vertices behaves as one
    write_vertex_count(5'd0);
    send_edge(4'd0, 4'd1, 1'b1);
    // oversized count saturates; four-clique
    write_vertex_count(5'd31);
    send_edge(4'd0, 4'd1, 1'b0);
    send_edge(4'd0, 4'd2, 1'b0);
    send_edge(4'd0, 4'd3, 1'b0);
    send_edge(4'd1, 4'd2, 1'b0);
    send_edge(4'd1, 4'd3, 1'b0);
    send_edge(4'd3, 4'd2, 1'b1);
    // edges past the vertex count are stored but not searched
    write_vertex_count(5'd2);
    send_edge(4'd7, 4'd0, 1'b0);
    send_edge(4'd0, 4'd1, 1'b1);
    send_edge(4'd1, 4'd0, 1'b0);
    send_edge(4'd9, 4'd9, 1'b1);

    // Random rounds: light sender gaps, heavy gaps, then back to back
    for (round = 0; round < 3; round++) begin
      send_idle_pct = (round == 0) ? 8 : (round == 1) ? 45 : 0;
      target        = items_sent + ROUND_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 60)      vc = COUNT_W'($urandom_range(2, 8));
        else if (r < 75) vc = 5'd16;
        else if (r < 82) vc = 5'd0;
        else if (r < 89) vc = 5'd1;
        else             vc = COUNT_W'($urandom_range(9, 31));
        write_vertex_count(vc);
        repeat ($urandom_range(1, 3)) send_random_graph();
      end
    end

    start <= 1'b0;
    while (sb.expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d edge requests, %0d graphs colored and checked, %0d count writes",
             sb.edges_taken, sb.graphs_checked, cfg_writes);
    $display("summary: vertex counts from 0 to 31, sender gaps of 8%%, 45%% and none");
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
